// ===== rtl/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// TEA cipher package
// Shared types, constants and the round mixing function of the TEA engine.
// ----------------------------------------------------------------------------
package tea_pkg;

	localparam int unsigned TEA_ROUNDS = 32;
	localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;
	localparam int unsigned TEA_ADDR_W = 4;

	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;
	localparam logic [1:0] REG_KEY3 = 2'd3;

	typedef struct packed {
		logic        func;
		logic [31:0] left_word;
		logic [31:0] right_word;
	} tea_req_t;

	typedef struct packed {
		logic [31:0] out_left;
		logic [31:0] out_right;
	} tea_rsp_t;

	typedef struct packed {
		logic        func;
		logic [31:0] y;
		logic [31:0] z;
	} tea_stage_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} tea_key_t;

	function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] s,
		input logic [31:0] ka, input logic [31:0] kb);
		tea_mix = ({x[27:0], 4'b0000} + ka) ^ (x + s) ^ ({5'b00000, x[31:5]} + kb);
	endfunction

endpackage

// ===== rtl/tea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher engine
// Pipelined 64-bit block encrypt/decrypt under a 128-bit key.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready/req_data, each holding a mode bit and
// the two 32-bit halves of a block. Results leave on rsp_valid/rsp_ready/
// rsp_data with the processed halves, in request order.
// The key is written through the APB-style port: key_word0..3 at byte
// addresses 0, 4, 8 and 12. Write it only while no request is in flight.
// Each stage computes one half of a Feistel cycle, so the pipeline has
// 2*ROUNDS stages, and each request passes through the stage registers in
// order on its way to the output. One request is accepted every cycle while
// the receiver does not stall.
// When the receiver stalls, the results stay in place and empty stages still
// fill, so requests are taken until the whole pipeline holds data.
// Reset empties the pipeline and clears the key to zero.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
	parameter int unsigned ROUNDS = tea_pkg::TEA_ROUNDS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  tea_pkg::tea_req_t              req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output tea_pkg::tea_rsp_t              rsp_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tea_pkg::TEA_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import tea_pkg::*;

	localparam int unsigned NSTAGE = 2 * ROUNDS;

	tea_key_t   key;
	logic       valid_c [0:NSTAGE];
	logic       ready_c [0:NSTAGE];
	tea_stage_t data_c  [0:NSTAGE];

	tea_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	assign valid_c[0]     = req_valid;
	assign req_ready      = ready_c[0];
	assign data_c[0].func = req_data.func;
	assign data_c[0].y    = req_data.left_word;
	assign data_c[0].z    = req_data.right_word;

	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		localparam logic [31:0] SUM_ENC = TEA_DELTA * 32'(i / 2 + 1);
		localparam logic [31:0] SUM_DEC = TEA_DELTA * 32'(ROUNDS - i / 2);
		tea_round_stage #(
			.SUM_ENC (SUM_ENC),
			.SUM_DEC (SUM_DEC),
			.SECOND  (bit'(i % 2))
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_data  (data_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_data  (data_c[i+1])
		);
	end

	assign ready_c[NSTAGE]    = rsp_ready;
	assign rsp_valid          = valid_c[NSTAGE];
	assign rsp_data.out_left  = data_c[NSTAGE].y;
	assign rsp_data.out_right = data_c[NSTAGE].z;

endmodule

// ===== rtl/tea_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// TEA key registers
// APB-style register file holding the four 32-bit key words.
// ----------------------------------------------------------------------------
module tea_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tea_pkg::TEA_ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output tea_pkg::tea_key_t             key
);
	import tea_pkg::*;

	tea_key_t key_q;
	logic     wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign key    = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_KEY0: key_q.k0 <= pwdata;
				REG_KEY1: key_q.k1 <= pwdata;
				REG_KEY2: key_q.k2 <= pwdata;
				REG_KEY3: key_q.k3 <= pwdata;
				default: key_q <= key_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KEY0: prdata = key_q.k0;
			REG_KEY1: prdata = key_q.k1;
			REG_KEY2: prdata = key_q.k2;
			REG_KEY3: prdata = key_q.k3;
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/tea_round_stage.sv =====
// ----------------------------------------------------------------------------
// TEA half-round stage
// One registered half of a Feistel cycle, for either direction, with its own
// valid bit and a ready that lets bubbles collapse.
// ----------------------------------------------------------------------------
module tea_round_stage #(
	parameter logic [31:0] SUM_ENC = 32'h0,
	parameter logic [31:0] SUM_DEC = 32'h0,
	parameter bit          SECOND  = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tea_pkg::tea_key_t   key,
	input  logic                up_valid,
	output logic                up_ready,
	input  tea_pkg::tea_stage_t up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output tea_pkg::tea_stage_t dn_data
);
	import tea_pkg::*;

	logic        valid_s1;
	tea_stage_t  data_s1;
	tea_stage_t  nxt;
	logic [31:0] sum;
	logic        dec;

	assign dec = (up_data.func == FUNC_DECRYPT);
	assign sum = dec ? SUM_DEC : SUM_ENC;

	always_comb begin
		nxt = up_data;
		if (!SECOND) begin
			if (!dec) begin
				nxt.y = up_data.y + tea_mix(up_data.z, sum, key.k0, key.k1);
			end else begin
				nxt.z = up_data.z - tea_mix(up_data.y, sum, key.k2, key.k3);
			end
		end else begin
			if (!dec) begin
				nxt.z = up_data.z + tea_mix(up_data.y, sum, key.k2, key.k3);
			end else begin
				nxt.y = up_data.y - tea_mix(up_data.z, sum, key.k0, key.k1);
			end
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

// ===== rtl/tea_checker.sv =====
// ----------------------------------------------------------------------------
// TEA port checker
// Concurrent checks on the top-level ports of the cipher engine.
// ----------------------------------------------------------------------------
module tea_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input tea_pkg::tea_req_t              req_data,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input tea_pkg::tea_rsp_t              rsp_data,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [tea_pkg::TEA_ADDR_W-1:0] paddr,
	input logic [31:0]                    pwdata,
	input logic [31:0]                    prdata,
	input logic                           pready
);
	import tea_pkg::*;

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("request refused while the output drains");

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with an empty output stage");

	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite ##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
		else $error("key register read back wrong value");

endmodule

bind tea_block_cipher tea_checker u_tea_checker (.*);

// ===== verif/tea_block_cipher_test.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher engine testbench
// Sends 64-bit blocks for encryption and decryption under several keys that are
// loaded through the APB port. The request and result channels idle at random,
// but for one key pass. Every result is checked against a local TEA predictor.
// ----------------------------------------------------------------------------
module tea_block_cipher_test;

	timeunit 1ns;
	timeprecision 1ps;

	import tea_pkg::*;

	localparam int unsigned CYCLES = TEA_ROUNDS;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned IDLE_PCT = 21;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	tea_req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	tea_rsp_t rsp_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [TEA_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tea_req_t blocks_pending [$];
	tea_rsp_t results_due [$];
	tea_key_t key_state = '0;
	logic steady = 1'b0;
	int unsigned err_count = 0;
	int unsigned n_encrypt = 0;
	int unsigned n_decrypt = 0;
	int unsigned n_results = 0;
	int unsigned n_keys = 0;
	int unsigned quiet_cycles = 0;

	tea_block_cipher #(
		.ROUNDS(CYCLES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] feistel_mix(input logic [31:0] x, input logic [31:0] s,
		input logic [31:0] ka, input logic [31:0] kb);
		logic [31:0] shl;
		logic [31:0] shr;
		shl = x << 4;
		shr = x >> 5;
		return (shl + ka) ^ (x + s) ^ (shr + kb);
	endfunction

	function automatic tea_rsp_t cipher_predict(input tea_req_t req, input tea_key_t key);
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] s;
		tea_rsp_t res;
		y = req.left_word;
		z = req.right_word;
		if (req.func == FUNC_ENCRYPT) begin
			s = '0;
			for (int unsigned n = 0; n < CYCLES; n++) begin
				s = s + TEA_DELTA;
				y = y + feistel_mix(z, s, key.k0, key.k1);
				z = z + feistel_mix(y, s, key.k2, key.k3);
			end
		end else begin
			s = TEA_DELTA * 32'(CYCLES);
			for (int unsigned n = 0; n < CYCLES; n++) begin
				z = z - feistel_mix(y, s, key.k2, key.k3);
				y = y - feistel_mix(z, s, key.k0, key.k1);
				s = s - TEA_DELTA;
			end
		end
		res.out_left = y;
		res.out_right = z;
		return res;
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		case ($urandom_range(0, 7))
			0: w = 32'h0000_0000;
			1: w = 32'hFFFF_FFFF;
			2: w = 32'h1 << $urandom_range(0, 31);
			3: w = ~(32'h1 << $urandom_range(0, 31));
			4: w = 32'($urandom_range(0, 255));
			default: w = $urandom();
		endcase
		return w;
	endfunction

	task automatic queue_block(input logic func, input logic [31:0] l, input logic [31:0] r);
		tea_req_t req;
		req.func = func;
		req.left_word = l;
		req.right_word = r;
		blocks_pending.push_back(req);
	endtask

	// The second block is the prediction of the first run in the other direction,
	// so the block should come back to its original value.
	task automatic queue_round_trip(input logic func, input logic [31:0] l,
		input logic [31:0] r);
		tea_req_t req;
		tea_rsp_t res;
		req.func = func;
		req.left_word = l;
		req.right_word = r;
		res = cipher_predict(req, key_state);
		queue_block(func, l, r);
		queue_block(~func, res.out_left, res.out_right);
	endtask

	task automatic write_key(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KEY0: key_state.k0 = val;
			REG_KEY1: key_state.k1 = val;
			REG_KEY2: key_state.k2 = val;
			REG_KEY3: key_state.k3 = val;
			default: ;
		endcase
	endtask

	task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
		input logic [31:0] k2, input logic [31:0] k3);
		write_key(REG_KEY0, k0);
		write_key(REG_KEY1, k1);
		write_key(REG_KEY2, k2);
		write_key(REG_KEY3, k3);
		n_keys++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (blocks_pending.size() != 0 || req_valid || results_due.size() != 0);
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_round_trip(1'($urandom_range(0, 1)), pick_word(), pick_word());
				sent += 2;
			end else begin
				queue_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
				sent++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
		end else begin
			if (req_valid && req_ready) begin
				results_due.push_back(cipher_predict(req_data, key_state));
				if (req_data.func == FUNC_ENCRYPT)
					n_encrypt++;
				else
					n_decrypt++;
			end
			if (!req_valid || req_ready) begin
				if (blocks_pending.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					req_valid <= 1'b1;
					req_data <= blocks_pending.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		tea_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_results++;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h %h",
						$time, rsp_data.out_left, rsp_data.out_right);
					err_count++;
				end else begin
					want = results_due.pop_front();
					if (rsp_data.out_left !== want.out_left) begin
						$display("%0t: out_left mismatch, expected %h, actual %h",
							$time, want.out_left, rsp_data.out_left);
						err_count++;
					end
					if (rsp_data.out_right !== want.out_right) begin
						$display("%0t: out_right mismatch, expected %h, actual %h",
							$time, want.out_right, rsp_data.out_right);
						err_count++;
					end
				end
			end
			rsp_ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((blocks_pending.size() != 0 || req_valid || results_due.size() != 0) &&
				!(req_valid && req_ready) && !(rsp_valid && rsp_ready) && !psel)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] k [4];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed blocks under the all-zero reset key.
		queue_block(FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		queue_block(FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		queue_block(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_block(FUNC_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_block(FUNC_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		queue_block(FUNC_DECRYPT, 32'h0000_0001, 32'h8000_0000);
		queue_block(FUNC_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_block(FUNC_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_block(FUNC_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
		queue_block(FUNC_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF);
		queue_round_trip(FUNC_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		queue_round_trip(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_round_trip(FUNC_ENCRYPT, 32'h7FFF_FFFF, 32'h8000_0000);
		wait_drained();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: k = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
				1: k = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
				2: k = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
				6: k = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
				default: k = '{$urandom(), $urandom(), $urandom(), $urandom()};
			endcase
			load_key(k[0], k[1], k[2], k[3]);
			if (p == 1)
				queue_round_trip(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			steady = (p == 3);
			queue_random(130);
			wait_drained();
			steady = 1'b0;
		end

		repeat (2 * CYCLES + 10) @(posedge clk);
		$display("Covered %0d encrypt and %0d decrypt requests, %0d results checked,",
			n_encrypt, n_decrypt, n_results);
		$display("under the reset key and %0d loaded keys, with idling on both sides.",
			n_keys);
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
